### hdl/pcht_pkg.sv
// ----------------------------------------------------------------------------
// pcht_pkg: shared types and constants for the PC sample hotspot tracker
// Holds the request and result structs, config indexes and the controller
// command/status structs.
// ----------------------------------------------------------------------------
package pcht_pkg;

  localparam int CpusDef  = 8;
  localparam int SlotsDef = 4;
  localparam int MaxLines = 8;
  localparam int NameBytes = 15;
  localparam int PctScale = 100;

  localparam logic [1:0] CFG_GRAIN  = 2'd0;
  localparam logic [1:0] CFG_ACTIVE = 2'd1;

  typedef struct packed {
    logic        kind;
    logic [5:0]  cpu;
    logic        busy_req;
    logic [63:0] pc;
    logic [30:0] task_pid;
    logic [63:0] name_lo;
    logic [63:0] name_hi;
  } pcht_in_t;

  typedef struct packed {
    logic [2:0]  out_cpu;
    logic [30:0] out_pid;
    logic [63:0] out_name_lo;
    logic [63:0] out_name_hi;
    logic [63:0] hot_pc;
    logic [6:0]  percent;
    logic        last;
  } pcht_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic samp_upd;  // apply sample after slot scan
    logic scan_step; // advance slot scan
    logic div_start; // start percent division
    logic div_step;
    logic emit;      // stage result in out register
    logic clr_start; // rewind pointer for the clearing sweep
    logic clr_step;  // clear one cpu row
    logic rep_next;  // next cpu in report
  } pcht_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic row_ok;    // current report cpu has something to show
    logic rep_end;   // current report cpu is last scanned
    logic clr_end;   // clear pointer on last row
    logic counted;   // captured sample is counted
    logic is_rep;
  } pcht_sts_t;

  // keep name bytes up to first zero, at most NameBytes
  function automatic logic [127:0] trim_name(input logic [63:0] lo, input logic [63:0] hi);
    logic [127:0] src;
    logic [127:0] res;
    logic         alive;
    src = {hi, lo};
    res = '0;
    alive = 1'b1;
    for (int j = 0; j < NameBytes; j++) begin
      if (src[j*8 +: 8] == 8'd0) alive = 1'b0;
      if (alive) res[j*8 +: 8] = src[j*8 +: 8];
    end
    return res;
  endfunction

endpackage

### hdl/pcht_datapath.sv
// ----------------------------------------------------------------------------
// pcht_datapath: slot table, per-CPU records and percent divider
// Scans one slot per cycle, divides hits*100 by total one bit per cycle.
// ----------------------------------------------------------------------------
module pcht_datapath
  import pcht_pkg::*;
#(
  parameter int CPUS  = CpusDef,
  parameter int SLOTS = SlotsDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  pcht_in_t  req_i,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  pcht_cmd_t cmd_i,
  output pcht_sts_t sts_o,
  output pcht_out_t res_o
);

  localparam int CW  = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int SW  = $clog2(SLOTS);
  localparam int SCW = $clog2(SLOTS + 1);
  localparam int DW  = 39; // hits*100 width
  localparam int QW  = 7;

  logic [63:0] slot_pc_r   [CPUS][SLOTS];
  logic [31:0] slot_hits_r [CPUS][SLOTS];
  logic [31:0] total_r     [CPUS];
  logic [30:0] pid_r       [CPUS];
  logic [127:0] name_r     [CPUS];

  logic [3:0] grain_r, active_r;
  pcht_in_t   req_r;
  logic [63:0] rpc_r;
  logic [SCW-1:0] sidx_r;
  logic [SW-1:0]  sel_r;      // worst (sample) or best (report)
  logic           match_r;
  logic [CW-1:0]  cur_r;      // report / clear pointer
  logic [3:0]     nlim_r;
  logic [DW-1:0]  rem_r;
  logic [DW-1:0]  num_r;
  logic [QW-1:0]  quo_r;
  logic [5:0]     dcnt_r;
  pcht_out_t      res_r;

  logic [CW-1:0]  row;
  logic [SW-1:0]  si;
  logic [63:0]    mask;
  logic [3:0]     ncl;

  assign row  = req_r.kind ? cur_r : req_r.cpu[CW-1:0];
  assign si   = sidx_r[SW-1:0];
  assign mask = (64'd1 << grain_r) - 64'd1;

  always_comb begin
    ncl = (active_r == 4'd0) ? 4'd1 : active_r;
    if (32'(ncl) > CPUS) ncl = 4'(CPUS);
    if (32'(ncl) > MaxLines) ncl = 4'(MaxLines);
  end

  assign sts_o.scan_done = (sidx_r == SCW'(SLOTS)) || match_r;
  assign sts_o.div_done  = (dcnt_r == 6'd0);
  assign sts_o.row_ok    = (total_r[cur_r] != 32'd0) && (slot_hits_r[cur_r][sel_r] != 32'd0);
  assign sts_o.rep_end   = (4'(cur_r) + 4'd1 >= nlim_r);
  assign sts_o.clr_end   = (32'(cur_r) == CPUS - 1);
  assign sts_o.counted   = req_r.busy_req && (32'(req_r.cpu) < CPUS);
  assign sts_o.is_rep    = req_r.kind;
  assign res_o = res_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grain_r  <= 4'd4;
      active_r <= 4'd1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_GRAIN)  grain_r  <= cfg_data_i;
      if (cfg_idx_i == CFG_ACTIVE) active_r <= cfg_data_i;
    end
  end

  // table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CPUS; c++) begin
        total_r[c] <= '0;
        pid_r[c]   <= '0;
        name_r[c]  <= '0;
        for (int s = 0; s < SLOTS; s++) begin
          slot_hits_r[c][s] <= '0;
          slot_pc_r[c][s]   <= '0;
        end
      end
    end else begin
      if (cmd_i.samp_upd) begin
        pid_r[row]   <= req_r.task_pid;
        name_r[row]  <= trim_name(req_r.name_lo, req_r.name_hi);
        if (total_r[row] != '1) total_r[row] <= total_r[row] + 32'd1;
        if (match_r) begin
          if (slot_hits_r[row][sel_r] != '1)
            slot_hits_r[row][sel_r] <= slot_hits_r[row][sel_r] + 32'd1;
        end else begin
          slot_pc_r[row][sel_r]   <= rpc_r;
          slot_hits_r[row][sel_r] <= 32'd1;
        end
      end
      if (cmd_i.clr_step) begin
        total_r[cur_r] <= '0;
        for (int s = 0; s < SLOTS; s++) begin
          slot_hits_r[cur_r][s] <= '0;
          slot_pc_r[cur_r][s]   <= '0;
        end
      end
    end
  end

  // request capture, slot scan, divider, result register
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      req_r   <= req_i;
      rpc_r   <= req_i.pc & ~mask;
      sidx_r  <= '0;
      sel_r   <= '0;
      match_r <= 1'b0;
      cur_r   <= '0;
      nlim_r  <= ncl;
    end
    if (cmd_i.scan_step) begin
      if (req_r.kind) begin
        if (slot_hits_r[row][si] > slot_hits_r[row][sel_r]) sel_r <= si;
      end else if (slot_hits_r[row][si] != 0 && slot_pc_r[row][si] == rpc_r) begin
        sel_r   <= si;
        match_r <= 1'b1;
      end else if (slot_hits_r[row][si] < slot_hits_r[row][sel_r]) begin
        sel_r <= si;
      end
      sidx_r <= sidx_r + SCW'(1);
    end
    if (cmd_i.clr_start) cur_r <= '0;
    if (cmd_i.rep_next) begin
      cur_r  <= cur_r + CW'(1);
      sidx_r <= '0;
      sel_r  <= '0;
    end
    if (cmd_i.div_start) begin
      num_r  <= DW'(slot_hits_r[cur_r][sel_r]) * DW'(PctScale);
      rem_r  <= '0;
      quo_r  <= '0;
      dcnt_r <= 6'(DW);
    end else if (cmd_i.div_step) begin
      logic [DW:0] t;
      t = {rem_r, num_r[DW-1]};
      num_r <= num_r << 1;
      if (t >= (DW+1)'(total_r[cur_r])) begin
        rem_r <= DW'(t - (DW+1)'(total_r[cur_r]));
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= DW'(t);
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 6'd1;
    end
    if (cmd_i.emit) begin
      res_r.out_cpu     <= 3'(cur_r);
      res_r.out_pid     <= pid_r[cur_r];
      res_r.out_name_lo <= name_r[cur_r][63:0];
      res_r.out_name_hi <= name_r[cur_r][127:64];
      res_r.hot_pc      <= slot_pc_r[cur_r][sel_r];
      res_r.percent     <= quo_r;
      res_r.last        <= 1'b1;
    end
    // a later row with output clears the previous line's last flag
    if (cmd_i.div_start) res_r.last <= 1'b0;
  end

endmodule

### hdl/pcht_ctrl.sv
// ----------------------------------------------------------------------------
// pcht_ctrl: sequencer for samples, reports and the clearing sweep
// A report line is held in the output register; the last line is released
// only after the remaining CPUs are known to have nothing to show.
// ----------------------------------------------------------------------------
module pcht_ctrl
  import pcht_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  pcht_sts_t sts_i,
  output pcht_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;
  localparam logic [2:0] S_NEXT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       held_r, held_nxt;   // staged line not yet shown
  logic       ov_r, ov_nxt;

  assign in_ready_o  = (state_r == S_IDLE);
  assign out_valid_o = ov_r;

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    ov_nxt    = ov_r;
    cmd_o     = '0;
    if (ov_r && out_ready_i) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.is_rep && !sts_i.scan_done) cmd_o.scan_step = 1'b1;
        else if (!sts_i.is_rep && !sts_i.scan_done) cmd_o.scan_step = 1'b1;
        else if (!sts_i.is_rep) state_nxt = sts_i.counted ? S_UPD : S_IDLE;
        else if (sts_i.row_ok) begin
          // show the staged line now; div_start drops its last flag on the same edge
          if (!held_r || !ov_r || out_ready_i) begin
            if (held_r) begin
              ov_nxt   = 1'b1;
              held_nxt = 1'b0;
            end
            cmd_o.div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end else state_nxt = S_NEXT;
      end
      S_UPD: begin
        cmd_o.samp_upd = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DIV: begin
        if (!sts_i.div_done) cmd_o.div_step = 1'b1;
        else if (!ov_r || out_ready_i) begin
          cmd_o.emit = 1'b1;
          held_nxt   = 1'b1;
          state_nxt  = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts_i.rep_end) state_nxt = S_WAIT;
        else begin
          cmd_o.rep_next = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_WAIT: begin
        if (held_r) begin
          if (!ov_r || out_ready_i) begin
            ov_nxt   = 1'b1;
            held_nxt = 1'b0;
          end
        end else if (!ov_r || out_ready_i) begin
          cmd_o.clr_start = 1'b1;
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_end) state_nxt = S_IDLE;
        else cmd_o.rep_next = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

### hdl/pc_sample_hotspot_tracker_core.sv
// ----------------------------------------------------------------------------
// pc_sample_hotspot_tracker_core: per-CPU hot program counter tracker
// Usage: send sample and report requests on in_valid/in_ready as one packed
// struct. A sample (kind 0) that is busy and has cpu below CPUS updates that
// CPU's pid, name, total and slot table. A report (kind 1) emits one line per
// scanned CPU with a nonzero total, on out_valid/out_ready, with last set on
// the final line, then clears all totals and slots (pids and names kept).
// Configuration: cfg_valid/cfg_ready with cfg_index (0 grain_log2,
// 1 active_cpus) and cfg_data; write only while idle.
// Sequence: a sample runs the one-slot-a-cycle slot scan, which stops early on
// a matching slot, then updates the table if counted. A report scans each
// scanned CPU's slots, runs the 39-step bit-serial percent divider for each
// reported CPU and stages its line, then releases the last line and runs the
// clearing sweep over all CPUS.
// One request is handled at a time. A stalled receiver holds the current line
// in the output register and pauses the report until it is taken.
// Reset: synchronous active low; clears all tables and counters, grain 4,
// active_cpus 1. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module pc_sample_hotspot_tracker_core
  import pcht_pkg::*;
#(
  parameter int CPUS  = CpusDef,
  parameter int SLOTS = SlotsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  pcht_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output pcht_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);

  pcht_cmd_t cmd;
  pcht_sts_t sts;

  assign cfg_ready = 1'b1;

  pcht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire_i  (in_valid && in_ready),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcht_datapath #(.CPUS(CPUS), .SLOTS(SLOTS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_i      (in_data),
    .cfg_we_i   (cfg_valid),
    .cfg_idx_i  (cfg_index),
    .cfg_data_i (cfg_data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (out_data)
  );

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the PC sample hotspot tracker
// Random and directed sample/report requests with random idling on both
// channels; a scoreboard predicts report lines and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pcht_pkg::*;

  localparam int NCPU = 8;
  localparam int NSLOT = 4;
  localparam int CYCLE_LIMIT = 1500000;

  // hotspot predictor and queue of expected report lines
  class hotspot_board;
    logic [63:0] slot_pc [NCPU*NSLOT];
    logic [31:0] slot_hits [NCPU*NSLOT];
    logic [31:0] total [NCPU];
    logic [30:0] pid [NCPU];
    logic [127:0] name [NCPU];
    logic [3:0] grain;
    logic [3:0] active;
    pcht_out_t lines[$];
    int errors;
    int n_lines;

    function void clear_all();
      for (int i = 0; i < NCPU*NSLOT; i++) begin
        slot_pc[i] = '0;
        slot_hits[i] = '0;
      end
      for (int i = 0; i < NCPU; i++) begin
        total[i] = '0;
        pid[i] = '0;
        name[i] = '0;
      end
      grain = 4'd4;
      active = 4'd1;
      errors = 0;
      n_lines = 0;
    endfunction

    // note one accepted request and predict its report lines
    function void note_request(pcht_in_t r);
      logic [63:0] pcr, mask;
      logic [127:0] src, nm;
      logic alive;
      int c, b, w, n, best, cnt;
      pcht_out_t o;
      if (!r.kind) begin
        c = r.cpu;
        if (c >= NCPU || !r.busy_req) return;
        mask = (64'd1 << grain) - 64'd1;
        pcr = r.pc & ~mask;
        pid[c] = r.task_pid;
        src = {r.name_hi, r.name_lo};
        nm = '0;
        alive = 1'b1;
        for (int j = 0; j < 15; j++) begin
          if (src[j*8 +: 8] == 8'd0) alive = 1'b0;
          if (alive) nm[j*8 +: 8] = src[j*8 +: 8];
        end
        name[c] = nm;
        if (total[c] != 32'hFFFFFFFF) total[c]++;
        b = c * NSLOT;
        w = 0;
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_hits[b+i] != 0 && slot_pc[b+i] == pcr) begin
            if (slot_hits[b+i] != 32'hFFFFFFFF) slot_hits[b+i]++;
            return;
          end
          if (slot_hits[b+i] < slot_hits[b+w]) w = i;
        end
        slot_pc[b+w] = pcr;
        slot_hits[b+w] = 32'd1;
      end else begin
        n = active;
        if (n == 0) n = 1;
        if (n > NCPU) n = NCPU;
        cnt = 0;
        for (int i = 0; i < n; i++) begin
          b = i * NSLOT;
          if (total[i] == 0) continue;
          best = 0;
          for (int k = 1; k < NSLOT; k++)
            if (slot_hits[b+k] > slot_hits[b+best]) best = k;
          if (slot_hits[b+best] == 0) continue;
          o.out_cpu = 3'(i);
          o.out_pid = pid[i];
          o.out_name_lo = name[i][63:0];
          o.out_name_hi = name[i][127:64];
          o.hot_pc = slot_pc[b+best];
          o.percent = 7'((64'(slot_hits[b+best]) * 100) / 64'(total[i]));
          o.last = 1'b0;
          lines.push_back(o);
          cnt++;
        end
        if (cnt > 0) lines[lines.size()-1].last = 1'b1;
        for (int i = 0; i < NCPU*NSLOT; i++) begin
          slot_pc[i] = '0;
          slot_hits[i] = '0;
        end
        for (int i = 0; i < NCPU; i++) total[i] = '0;
      end
    endfunction

    function void check_line(pcht_out_t a);
      pcht_out_t e;
      n_lines++;
      if (lines.size() == 0) begin
        $error("unexpected report line cpu=%0d", a.out_cpu);
        errors++;
        return;
      end
      e = lines.pop_front();
      if (a.out_cpu !== e.out_cpu) begin
        $error("out_cpu exp %0d got %0d", e.out_cpu, a.out_cpu); errors++;
      end
      if (a.out_pid !== e.out_pid) begin
        $error("out_pid exp %0h got %0h", e.out_pid, a.out_pid); errors++;
      end
      if (a.out_name_lo !== e.out_name_lo) begin
        $error("out_name_lo exp %0h got %0h", e.out_name_lo, a.out_name_lo); errors++;
      end
      if (a.out_name_hi !== e.out_name_hi) begin
        $error("out_name_hi exp %0h got %0h", e.out_name_hi, a.out_name_hi); errors++;
      end
      if (a.hot_pc !== e.hot_pc) begin
        $error("hot_pc exp %0h got %0h", e.hot_pc, a.hot_pc); errors++;
      end
      if (a.percent !== e.percent) begin
        $error("percent exp %0d got %0d", e.percent, a.percent); errors++;
      end
      if (a.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pcht_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pcht_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_GRAIN;
  logic [3:0] cfg_data = '0;

  hotspot_board board;
  int send_idle_pct = 8;
  int recv_idle_pct = 67;
  int cycles = 0;
  int n_requests = 0;
  logic [63:0] hot_pcs [4];

  always #2 clk = ~clk;

  pc_sample_hotspot_tracker_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stall, check on accept
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_line(out_data);
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays up after an accept until the next request or an idle cycle
  task automatic send_request(input pcht_in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(r);
    n_requests++;
  endtask

  // wait for drain, then pass the worst-case report tail
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.lines.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_GRAIN) board.grain = val;
    else board.active = val;
  endtask

  function automatic pcht_in_t rand_sample();
    pcht_in_t r;
    r.kind = 1'b0;
    r.cpu = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(7));
    r.busy_req = ($urandom_range(9) != 0);
    r.pc = ($urandom_range(3) == 0) ? {$urandom, $urandom}
           : hot_pcs[$urandom_range(3)] + 64'($urandom_range(40));
    r.task_pid = 31'($urandom);
    r.name_lo = {$urandom, $urandom};
    r.name_hi = {$urandom, $urandom};
    if ($urandom_range(2) == 0) r.name_lo[8*$urandom_range(7) +: 8] = 8'd0;
    return r;
  endfunction

  function automatic pcht_in_t report_req();
    pcht_in_t r;
    r.kind = 1'b1;
    r.cpu = 6'($urandom);
    r.busy_req = 1'($urandom);
    r.pc = {$urandom, $urandom};
    r.task_pid = 31'($urandom);
    r.name_lo = {$urandom, $urandom};
    r.name_hi = {$urandom, $urandom};
    return r;
  endfunction

  initial begin
    pcht_in_t r;
    logic [3:0] gsel[4] = '{4'd0, 4'd12, 4'd15, 4'd3};
    logic [3:0] asel[4] = '{4'd8, 4'd0, 4'd15, 4'd3};
    board = new();
    board.clear_all();
    for (int i = 0; i < 4; i++) hot_pcs[i] = {$urandom, $urandom};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty report, extremes, ignored samples, name cases
    send_request(report_req());
    r = '0; r.busy_req = 1'b1; send_request(r);
    r = '1; r.kind = 1'b0; r.cpu = 6'd7; send_request(r);
    r.cpu = 6'd63; send_request(r);
    r.cpu = 6'd8; send_request(r);
    r.cpu = 6'd0; r.busy_req = 1'b0; send_request(r);
    r = '1; r.kind = 1'b0; r.cpu = 6'd0; r.name_lo[23:16] = 8'd0; send_request(r);
    r.name_lo = '0; send_request(r);
    r = '1; r.kind = 1'b0; r.cpu = 6'd0; r.pc = 64'h5; send_request(r);
    send_request(report_req());
    write_reg(CFG_ACTIVE, 4'd8);
    write_reg(CFG_GRAIN, 4'd0);
    for (int i = 0; i < 8; i++) begin
      r = rand_sample(); r.cpu = i; r.busy_req = 1'b1; send_request(r);
    end
    for (int i = 0; i < 5; i++) begin
      r = rand_sample(); r.cpu = 6'd1; r.busy_req = 1'b1;
      r.pc = 64'h100 + i; send_request(r);
    end
    send_request(report_req());

    // random phases over idling profiles and register settings
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin send_idle_pct = 67; recv_idle_pct = 8; end
      if (ph == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_reg(CFG_GRAIN, gsel[ph % 4]);
      write_reg(CFG_ACTIVE, asel[(ph / 4 + ph) % 4]);
      for (int i = 0; i < 34; i++) begin
        if ($urandom_range(11) == 0) send_request(report_req());
        else send_request(rand_sample());
      end
      send_request(report_req());
    end

    wait_idle();
    $display("Covered %0d requests and %0d report lines across grain/CPU-count settings",
             n_requests, board.n_lines);
    if (board.errors == 0 && board.lines.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

### pc_sample_hotspot_tracker_core.f
hdl/pcht_pkg.sv
hdl/pcht_datapath.sv
hdl/pcht_ctrl.sv
hdl/pc_sample_hotspot_tracker_core.sv
sim/testbench.sv
